// ----- rtl/core/address_decoder_firing_core_assert.svh -----
// Assertion macros for the address decoder firing core.
// The including scope must provide signals named clock and reset.
`ifndef ADDRESS_DECODER_FIRING_CORE_ASSERT_SVH
`define ADDRESS_DECODER_FIRING_CORE_ASSERT_SVH

// Check that b holds in the same cycle as a.
`define ADFC_ASSERT_SAME(label, a, b, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error(msg);

// Check that b holds in the cycle after a.
`define ADFC_ASSERT_NEXT(label, a, b, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error(msg);

`endif

// ----- rtl/core/adfc_pkg.sv -----
// Shared constants, types and controller/datapath interface structs
// for the address decoder firing core. No dependencies.
package adfc_pkg;

   // Store geometry
   localparam int ELEMENT_COUNT = 2048;
   localparam int MAX_SYNAPSES  = 12;
   localparam int IMAGE_PIXELS  = 1024;

   // Arithmetic constants: weight is +/-64, applied as a shift
   localparam int PIXEL_OFFSET = 127;
   localparam int SYN_SHIFT    = 6;

   // Output word layout
   localparam int WORD_BITS  = 64;
   localparam int WORD_LIMIT = 32;
   localparam int WORD_RAW   = (ELEMENT_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_COUNT = (WORD_RAW > WORD_LIMIT) ? WORD_LIMIT : WORD_RAW;
   localparam int EVAL_ELEMS = WORD_COUNT * WORD_BITS;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int PIX_IDX_W  = 10;
   localparam int PIX_VAL_W  = 8;
   localparam int ELEM_IDX_W = 11;
   localparam int SLOT_W     = 4;
   localparam int POS_W      = 12;
   localparam int THR_W      = 18;
   localparam int WORD_IDX_W = 5;
   localparam int COUNT_W    = 4;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd6;

   // Request tdata layout, lowest field first
   localparam int PIX_IDX_LSB  = 0;
   localparam int PIX_VAL_LSB  = PIX_IDX_LSB + PIX_IDX_W;
   localparam int ELEM_IDX_LSB = PIX_VAL_LSB + PIX_VAL_W;
   localparam int SLOT_LSB     = ELEM_IDX_LSB + ELEM_IDX_W;
   localparam int POS_LSB      = SLOT_LSB + SLOT_W;
   localparam int THR_LSB      = POS_LSB + POS_W;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 72;

   // Memory address widths
   localparam int SYN_DEPTH = ELEMENT_COUNT * MAX_SYNAPSES;
   localparam int SYN_AW    = $clog2(SYN_DEPTH);
   localparam int ELEM_AW   = $clog2(ELEMENT_COUNT);
   localparam int PIX_AW    = $clog2(IMAGE_PIXELS);
   localparam int ITER_W    = $clog2(EVAL_ELEMS);

   // Sum width: 16-bit contributions accumulated, wide enough for the threshold
   localparam int CONTRIB_W = 16;
   localparam int SUM_RAW   = CONTRIB_W + $clog2(MAX_SYNAPSES);
   localparam int SUM_W     = ((SUM_RAW > THR_W) ? SUM_RAW : THR_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_PIXEL     = 2'd0,
      CMD_LOAD_SYNAPSE   = 2'd1,
      CMD_LOAD_THRESHOLD = 2'd2,
      CMD_EVALUATE       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_EVAL,
      CTRL_DRAIN
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic                  wr_pixel;
      logic                  wr_synapse;
      logic                  wr_threshold;
      logic                  issue;
      logic                  slot_used;
      logic                  first;
      logic                  last;
      logic                  pad;
      logic                  word_end;
      logic                  last_word;
      logic [WORD_IDX_W-1:0] word_index;
      logic [SYN_AW-1:0]     syn_addr;
      logic [ELEM_AW-1:0]    thr_addr;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic busy;
   } dp_status_type;

endpackage

// ----- rtl/core/adfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module adfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/adfc_ctrl.sv -----
// Sequencer for the address decoder firing core: accepts requests, holds the
// synapse count register and walks elements and slots. Uses adfc_pkg.
module adfc_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [adfc_pkg::CMD_W-1:0]         req_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [adfc_pkg::COUNT_W-1:0]       csr_data,
   input  adfc_pkg::dp_status_type            dp_status,
   output adfc_pkg::dp_cmd_type               dp_cmd
);

   adfc_pkg::ctrl_state_type            state_ff, state_in;
   logic [adfc_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [adfc_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic [adfc_pkg::ITER_W-1:0]         elem_ff, elem_in;
   logic [adfc_pkg::SYN_AW-1:0]         base_ff, base_in;
   logic [adfc_pkg::WORD_IDX_W-1:0]     word_ff, word_in;

   adfc_pkg::cmd_type                   req_cmd;
   logic [adfc_pkg::COUNT_W:0]          used;
   logic [adfc_pkg::SLOT_W-1:0]         last_slot;
   logic                                pad;
   logic                                slot_end;
   logic                                word_end;
   logic                                last_word;

   assign req_cmd = adfc_pkg::cmd_type'(req_tuser);

   // Saturate the synapse count and find the last slot of an element
   assign used = ((adfc_pkg::COUNT_W+1)'(count_ff) > (adfc_pkg::COUNT_W+1)'(adfc_pkg::MAX_SYNAPSES))
                 ? (adfc_pkg::COUNT_W+1)'(adfc_pkg::MAX_SYNAPSES)
                 : (adfc_pkg::COUNT_W+1)'(count_ff);
   assign last_slot = (used == '0) ? '0 : adfc_pkg::SLOT_W'(used - 1'b1);

   // Element and word position flags
   assign pad       = 32'(elem_ff) >= adfc_pkg::ELEMENT_COUNT;
   assign slot_end  = pad || (slot_ff == last_slot);
   assign word_end  = elem_ff[5:0] == 6'h3F;
   assign last_word = word_ff == adfc_pkg::WORD_IDX_W'(adfc_pkg::WORD_COUNT - 1);

   // Register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adfc_pkg::CTRL_IDLE;
         count_ff <= adfc_pkg::COUNT_RESET;
         slot_ff  <= '0;
         elem_ff  <= '0;
         base_ff  <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         slot_ff  <= slot_in;
         elem_ff  <= elem_in;
         base_ff  <= base_in;
         word_ff  <= word_in;
      end
   end

   // Take configuration writes at any time
   assign csr_ready = 1'b1;
   assign count_in  = csr_valid ? csr_data : count_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adfc_pkg::CTRL_IDLE: begin
            if (req_tvalid && req_cmd == adfc_pkg::CMD_EVALUATE) begin
               state_in = adfc_pkg::CTRL_EVAL;
            end
         end
         adfc_pkg::CTRL_EVAL: begin
            if (slot_end && word_end) begin
               state_in = adfc_pkg::CTRL_DRAIN;
            end
         end
         adfc_pkg::CTRL_DRAIN: begin
            if (!dp_status.busy) begin
               state_in = (word_ff == '0) ? adfc_pkg::CTRL_IDLE : adfc_pkg::CTRL_EVAL;
            end
         end
         default: state_in = adfc_pkg::CTRL_IDLE;
      endcase
   end

   // Clear the counters while idle; advance slot, element and word counters while evaluating
   always_comb begin
      slot_in = slot_ff;
      elem_in = elem_ff;
      base_in = base_ff;
      word_in = word_ff;
      if (state_ff == adfc_pkg::CTRL_IDLE) begin
         slot_in = '0;
         elem_in = '0;
         base_in = '0;
         word_in = '0;
      end else if (state_ff == adfc_pkg::CTRL_EVAL) begin
         if (slot_end) begin
            slot_in = '0;
            elem_in = elem_ff + 1'b1;
            base_in = base_ff + adfc_pkg::SYN_AW'(adfc_pkg::MAX_SYNAPSES);
            if (word_end) begin
               word_in = last_word ? '0 : word_ff + 1'b1;
            end
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   // Outputs
   always_comb begin
      dp_cmd            = '0;
      dp_cmd.syn_addr   = base_ff + adfc_pkg::SYN_AW'(slot_ff);
      dp_cmd.thr_addr   = adfc_pkg::ELEM_AW'(elem_ff);
      dp_cmd.word_index = word_ff;
      req_tready        = 1'b0;
      unique case (state_ff)
         adfc_pkg::CTRL_IDLE: begin
            req_tready          = 1'b1;
            dp_cmd.wr_pixel     = req_tvalid && req_cmd == adfc_pkg::CMD_LOAD_PIXEL;
            dp_cmd.wr_synapse   = req_tvalid && req_cmd == adfc_pkg::CMD_LOAD_SYNAPSE;
            dp_cmd.wr_threshold = req_tvalid && req_cmd == adfc_pkg::CMD_LOAD_THRESHOLD;
         end
         adfc_pkg::CTRL_EVAL: begin
            dp_cmd.issue     = 1'b1;
            dp_cmd.slot_used = !pad && (used != '0);
            dp_cmd.first     = slot_ff == '0;
            dp_cmd.last      = slot_end;
            dp_cmd.pad       = pad;
            dp_cmd.word_end  = word_end;
            dp_cmd.last_word = last_word;
         end
         adfc_pkg::CTRL_DRAIN: begin
            req_tready = 1'b0;
         end
         default: req_tready = 1'b0;
      endcase
   end

endmodule

// ----- rtl/core/adfc_datapath.sv -----
// Datapath of the address decoder firing core: the three stores, the
// synapse decode, accumulate and compare pipeline and the output register.
// Uses adfc_pkg and adfc_ram.
module adfc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [adfc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  adfc_pkg::dp_cmd_type               dp_cmd,
   output adfc_pkg::dp_status_type            dp_status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [adfc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   // Request fields
   logic [adfc_pkg::PIX_IDX_W-1:0]  pixel_index;
   logic [adfc_pkg::PIX_VAL_W-1:0]  pixel_value;
   logic [adfc_pkg::ELEM_IDX_W-1:0] element_index;
   logic [adfc_pkg::SLOT_W-1:0]     synapse_slot;
   logic [adfc_pkg::POS_W-1:0]      synapse_position;
   logic [adfc_pkg::THR_W-1:0]      firing_threshold;

   // Store ports
   logic                            pix_wr_en, syn_wr_en, thr_wr_en;
   logic [adfc_pkg::PIX_AW-1:0]     pix_wr_addr, pix_rd_addr;
   logic [adfc_pkg::SYN_AW-1:0]     syn_wr_addr;
   logic [adfc_pkg::ELEM_AW-1:0]    thr_wr_addr;
   logic [adfc_pkg::PIX_VAL_W-1:0]  pix_rd_data;
   logic [adfc_pkg::POS_W-1:0]      syn_rd_data;
   logic [adfc_pkg::THR_W-1:0]      thr_rd_data;

   // Stage 1: synapse and threshold read data
   logic                            s1_valid_ff;
   logic                            s1_used_ff, s1_first_ff, s1_last_ff, s1_pad_ff;
   logic                            s1_word_end_ff, s1_last_word_ff;
   logic [adfc_pkg::WORD_IDX_W-1:0] s1_index_ff;
   logic                            s1_neg;
   logic [adfc_pkg::POS_W-1:0]      s1_mag;
   logic                            s1_hit;

   // Stage 2: pixel read data
   logic                            s2_valid_ff;
   logic                            s2_hit_ff, s2_neg_ff, s2_first_ff, s2_last_ff, s2_pad_ff;
   logic                            s2_word_end_ff, s2_last_word_ff;
   logic [adfc_pkg::WORD_IDX_W-1:0] s2_index_ff;
   logic [adfc_pkg::THR_W-1:0]      s2_thr_ff;
   logic signed [9:0]               s2_diff;
   logic signed [adfc_pkg::CONTRIB_W-1:0] s2_scaled, s2_contrib;
   logic signed [adfc_pkg::SUM_W-1:0]     s2_sum, s2_thr_ext, acc_ff;
   logic                            s2_fire;
   logic                            word_done;

   // Word assembly and output
   logic [adfc_pkg::WORD_BITS-1:0]  build_ff;
   logic                            held_ff, held_in;
   logic [adfc_pkg::WORD_IDX_W-1:0] held_index_ff;
   logic                            held_last_ff;
   logic                            move;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [adfc_pkg::WORD_IDX_W-1:0] rsp_index_ff;
   logic [adfc_pkg::WORD_BITS-1:0]  rsp_bits_ff;
   logic                            rsp_last_ff;

   // Unpack request fields
   assign pixel_index      = req_tdata[adfc_pkg::PIX_IDX_LSB  +: adfc_pkg::PIX_IDX_W];
   assign pixel_value      = req_tdata[adfc_pkg::PIX_VAL_LSB  +: adfc_pkg::PIX_VAL_W];
   assign element_index    = req_tdata[adfc_pkg::ELEM_IDX_LSB +: adfc_pkg::ELEM_IDX_W];
   assign synapse_slot     = req_tdata[adfc_pkg::SLOT_LSB     +: adfc_pkg::SLOT_W];
   assign synapse_position = req_tdata[adfc_pkg::POS_LSB      +: adfc_pkg::POS_W];
   assign firing_threshold = req_tdata[adfc_pkg::THR_LSB      +: adfc_pkg::THR_W];

   // Drop loads whose address lies outside its store
   assign pix_wr_en = dp_cmd.wr_pixel && (32'(pixel_index) < adfc_pkg::IMAGE_PIXELS);
   assign syn_wr_en = dp_cmd.wr_synapse && (32'(synapse_slot) < adfc_pkg::MAX_SYNAPSES)
                      && (32'(element_index) < adfc_pkg::ELEMENT_COUNT);
   assign thr_wr_en = dp_cmd.wr_threshold && (32'(element_index) < adfc_pkg::ELEMENT_COUNT);

   assign pix_wr_addr = adfc_pkg::PIX_AW'(pixel_index);
   assign syn_wr_addr = adfc_pkg::SYN_AW'(32'(element_index) * adfc_pkg::MAX_SYNAPSES
                                          + 32'(synapse_slot));
   assign thr_wr_addr = adfc_pkg::ELEM_AW'(element_index);

   adfc_ram #(
      .WIDTH (adfc_pkg::PIX_VAL_W),
      .DEPTH (adfc_pkg::IMAGE_PIXELS)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr (pix_wr_addr),
      .wr_data (pixel_value),
      .rd_addr (pix_rd_addr),
      .rd_data (pix_rd_data)
   );

   adfc_ram #(
      .WIDTH (adfc_pkg::POS_W),
      .DEPTH (adfc_pkg::SYN_DEPTH)
   ) u_synapse_ram (
      .clock   (clock),
      .wr_en   (syn_wr_en),
      .wr_addr (syn_wr_addr),
      .wr_data (synapse_position),
      .rd_addr (dp_cmd.syn_addr),
      .rd_data (syn_rd_data)
   );

   adfc_ram #(
      .WIDTH (adfc_pkg::THR_W),
      .DEPTH (adfc_pkg::ELEMENT_COUNT)
   ) u_threshold_ram (
      .clock   (clock),
      .wr_en   (thr_wr_en),
      .wr_addr (thr_wr_addr),
      .wr_data (firing_threshold),
      .rd_addr (dp_cmd.thr_addr),
      .rd_data (thr_rd_data)
   );

   // Stage 1: decode sign and magnitude, address the pixel
   assign s1_neg      = syn_rd_data[adfc_pkg::POS_W-1];
   assign s1_mag      = s1_neg ? (~syn_rd_data + 1'b1) : syn_rd_data;
   assign s1_hit      = s1_used_ff && (syn_rd_data != '0)
                        && ((adfc_pkg::POS_W+1)'(s1_mag)
                            <= (adfc_pkg::POS_W+1)'(adfc_pkg::IMAGE_PIXELS));
   assign pix_rd_addr = adfc_pkg::PIX_AW'(s1_mag - 1'b1);

   // Stage 2: scale the pixel and accumulate
   assign s2_diff    = $signed({2'b00, pix_rd_data}) - 10'sd127;
   assign s2_scaled  = $signed({{(adfc_pkg::CONTRIB_W-10){s2_diff[9]}}, s2_diff})
                       <<< adfc_pkg::SYN_SHIFT;
   assign s2_contrib = s2_hit_ff ? (s2_neg_ff ? -s2_scaled : s2_scaled) : '0;
   assign s2_sum     = (s2_first_ff ? '0 : acc_ff)
                       + $signed({{(adfc_pkg::SUM_W-adfc_pkg::CONTRIB_W){s2_contrib[adfc_pkg::CONTRIB_W-1]}},
                                  s2_contrib});
   assign s2_thr_ext = $signed({{(adfc_pkg::SUM_W-adfc_pkg::THR_W){s2_thr_ff[adfc_pkg::THR_W-1]}},
                                s2_thr_ff});
   assign s2_fire    = !s2_pad_ff && (s2_sum >= s2_thr_ext);
   assign word_done  = s2_valid_ff && s2_last_ff && s2_word_end_ff;

   // Hand a finished word to the output register when it is free
   assign move         = held_ff && (!rsp_valid_ff || rsp_tready);
   assign held_in      = word_done || (held_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp_tready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= dp_cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_used_ff      <= dp_cmd.slot_used;
      s1_first_ff     <= dp_cmd.first;
      s1_last_ff      <= dp_cmd.last;
      s1_pad_ff       <= dp_cmd.pad;
      s1_word_end_ff  <= dp_cmd.word_end;
      s1_last_word_ff <= dp_cmd.last_word;
      s1_index_ff     <= dp_cmd.word_index;

      s2_hit_ff       <= s1_hit;
      s2_neg_ff       <= s1_neg;
      s2_first_ff     <= s1_first_ff;
      s2_last_ff      <= s1_last_ff;
      s2_pad_ff       <= s1_pad_ff;
      s2_word_end_ff  <= s1_word_end_ff;
      s2_last_word_ff <= s1_last_word_ff;
      s2_index_ff     <= s1_index_ff;
      s2_thr_ff       <= thr_rd_data;
   end

   // Accumulate and shift firing bits in, first element ending in bit 0
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= s2_sum;
         if (s2_last_ff) begin
            build_ff <= {s2_fire, build_ff[adfc_pkg::WORD_BITS-1:1]};
         end
      end
      if (word_done) begin
         held_index_ff <= s2_index_ff;
         held_last_ff  <= s2_last_word_ff;
      end
      if (move) begin
         rsp_index_ff <= held_index_ff;
         rsp_bits_ff  <= build_ff;
         rsp_last_ff  <= held_last_ff;
      end
   end

   assign dp_status.busy = s1_valid_ff || s2_valid_ff || held_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(adfc_pkg::RSP_DATA_W-adfc_pkg::WORD_BITS-adfc_pkg::WORD_IDX_W){1'b0}},
                        rsp_bits_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/core/address_decoder_firing_core.sv -----
// An evaluate produces 32 words; each element sums its first S synapse entries, S the
// saturated synapse_count. Throughput is set by the synapse memory read port: one
// synapse entry per cycle while a word is evaluated; between words the sequencer
// waits until the datapath has drained. Reset clears control and sets synapse_count
// to 6; stores are not cleared.
`include "address_decoder_firing_core_assert.svh"

module address_decoder_firing_core (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] pixel_index, [17:10] pixel_value, [28:18] element_index,
   // [32:29] synapse_slot, [44:33] synapse_position, [62:45] firing_threshold
   input  logic [adfc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [adfc_pkg::CMD_W-1:0]      req_tuser,
   // Response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [4:0] word_index, [68:5] fire_bits
   output logic [adfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // Synapse count register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [adfc_pkg::COUNT_W-1:0]    csr_data
);

   adfc_pkg::dp_cmd_type    dp_cmd;
   adfc_pkg::dp_status_type dp_status;

   // Sequencer
   adfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   // Stores, accumulator and output register
   adfc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A request is taken only when the pipeline is empty
   `ADFC_ASSERT_SAME(a_ready_idle, req_tready, !dp_status.busy, "ready while pipeline busy")

   // Store writes only on an accepted request
   `ADFC_ASSERT_SAME(a_write_on_transfer,
      dp_cmd.wr_pixel || dp_cmd.wr_synapse || dp_cmd.wr_threshold,
      req_tvalid && req_tready, "store write without request transfer")

   // Nothing follows the final word of an evaluation right away
   `ADFC_ASSERT_NEXT(a_last_word_final, rsp_tvalid && rsp_tready && rsp_tlast,
      !rsp_tvalid, "response after final word")

endmodule

// ----- dv/address_decoder_firing_core_checker.sv -----
// Checker for address_decoder_firing_core: mirrors the pixel, synapse and threshold stores,
// predicts the firing words of each evaluation and compares every response transfer.
// Depends on adfc_pkg for widths, store geometry and command codes.
module address_decoder_firing_core_checker
   import adfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_data,
   output int unsigned           fault_count,
   output int unsigned           words_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [WORD_IDX_W-1:0] word_index;
      logic [WORD_BITS-1:0]  fire_bits;
      logic                  last;
   } fire_word_t;

   // Mirror of the block's stores and synapse count register
   logic [PIX_VAL_W-1:0] image_px   [IMAGE_PIXELS];
   logic [POS_W-1:0]     syn_table  [SYN_DEPTH];
   logic [THR_W-1:0]     thresh_tab [ELEMENT_COUNT];
   logic [COUNT_W-1:0]   count_reg;

   // Firing words still owed by the block, oldest first
   fire_word_t fire_words_due [$];

   // Sum the used synapses of one element and test it against its threshold
   function automatic bit element_fires_now(input int unsigned elem, input int unsigned used);
      int                       sum;
      int                       entry;
      int                       mag;
      int                       gain;
      int unsigned              j;
      logic signed [POS_W-1:0]  entry_s;
      logic signed [THR_W-1:0]  thr_s;
      sum = 0;
      for (j = 0; j < used; j++) begin
         entry_s = syn_table[elem * MAX_SYNAPSES + j];
         entry   = entry_s;
         mag     = (entry < 0) ? -entry : entry;
         // skip unused entries and positions past the image
         if (entry != 0 && mag <= IMAGE_PIXELS) begin
            gain = (int'(image_px[mag - 1]) - PIXEL_OFFSET) * (1 << SYN_SHIFT);
            sum  = sum + ((entry < 0) ? -gain : gain);
         end
      end
      thr_s = thresh_tab[elem];
      return sum >= thr_s;
   endfunction

   // Queue every firing word of one evaluation
   task automatic compute_fire_words();
      fire_word_t  word;
      int unsigned used;
      int unsigned wi;
      int unsigned k;
      int unsigned elem;
      used = (count_reg > MAX_SYNAPSES) ? MAX_SYNAPSES : count_reg;
      for (wi = 0; wi < WORD_COUNT; wi++) begin
         word.word_index = WORD_IDX_W'(wi);
         word.fire_bits  = '0;
         for (k = 0; k < WORD_BITS; k++) begin
            elem = wi * WORD_BITS + k;
            if (elem < ELEMENT_COUNT)
               word.fire_bits[k] = element_fires_now(elem, used);
         end
         word.last = (wi == WORD_COUNT - 1);
         fire_words_due.push_back(word);
      end
   endtask

   task automatic log_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t ns: %s", $time, what);
   endtask

   // Track every transfer on the three channels
   always @(posedge clock) begin : watch_channels
      logic [REQ_DATA_W-1:0] cmd_data;
      logic [SLOT_W-1:0]     slot;
      logic [ELEM_IDX_W-1:0] elem;
      fire_word_t            due;
      fire_word_t            seen;
      if (reset) begin
         count_reg = COUNT_RESET;
         fire_words_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            count_reg = csr_data;

         // apply loads, predict evaluations
         if (req_tvalid && req_tready) begin
            cmd_data = req_tdata;
            elem     = cmd_data[ELEM_IDX_LSB +: ELEM_IDX_W];
            slot     = cmd_data[SLOT_LSB +: SLOT_W];
            case (cmd_type'(req_tuser))
               CMD_LOAD_PIXEL: begin
                  image_px[cmd_data[PIX_IDX_LSB +: PIX_IDX_W]] =
                     cmd_data[PIX_VAL_LSB +: PIX_VAL_W];
               end
               CMD_LOAD_SYNAPSE: begin
                  // drop writes to slots past the table
                  if (slot < MAX_SYNAPSES)
                     syn_table[elem * MAX_SYNAPSES + slot] = cmd_data[POS_LSB +: POS_W];
               end
               CMD_LOAD_THRESHOLD: begin
                  thresh_tab[elem] = cmd_data[THR_LSB +: THR_W];
               end
               CMD_EVALUATE: begin
                  compute_fire_words();
               end
               default: begin
                  log_fault($sformatf("request with unknown command %b", req_tuser));
               end
            endcase
         end

         // compare each response transfer with the oldest owed word
         if (rsp_tvalid && rsp_tready) begin
            seen.word_index = rsp_tdata[WORD_IDX_W-1:0];
            seen.fire_bits  = rsp_tdata[WORD_IDX_W +: WORD_BITS];
            seen.last       = rsp_tlast;
            if (fire_words_due.size() == 0) begin
               log_fault($sformatf("unexpected firing word: word_index %0d fire_bits %h last %b",
                                   seen.word_index, seen.fire_bits, seen.last));
            end else begin
               due = fire_words_due.pop_front();
               if (seen.word_index !== due.word_index)
                  log_fault($sformatf("word_index expected %0d, got %0d",
                                      due.word_index, seen.word_index));
               if (seen.fire_bits !== due.fire_bits)
                  log_fault($sformatf("word %0d fire_bits expected %h, got %h",
                                      due.word_index, due.fire_bits, seen.fire_bits));
               if (seen.last !== due.last)
                  log_fault($sformatf("word %0d last expected %b, got %b",
                                      due.word_index, due.last, seen.last));
            end
         end
      end
      words_outstanding <= fire_words_due.size();
   end

endmodule

// ----- dv/address_decoder_firing_core_test.sv -----
// Top of the address_decoder_firing_core testbench: clock, reset, request and register
// stimulus, response back-pressure and the final verdict.
// Depends on adfc_pkg, the core and address_decoder_firing_core_checker.
module address_decoder_firing_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import adfc_pkg::*;

   localparam int          RESET_CYCLES    = 9;
   localparam int          IDLE_GUARD      = 16;
   localparam int          TAIL_CYCLES     = 64 * MAX_SYNAPSES + 40;
   localparam int          LONG_HOLD       = 3000;
   localparam int          RANDOM_PHASES   = 4;
   localparam int          ITEMS_PER_PHASE = 24;
   localparam int unsigned CYCLE_LIMIT     = 2_000_000;
   localparam int          THR_MAX         = 131071;
   localparam int          THR_MIN         = -131072;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_data   = '0;

   int unsigned fault_count;
   int unsigned words_outstanding;
   int unsigned cycles_run  = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_given = 0;
   int          burst_left  = 0;

   always #10 clock = ~clock;

   address_decoder_firing_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   address_decoder_firing_core_checker firing_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .fault_count       (fault_count),
      .words_outstanding (words_outstanding)
   );

   // Signed pixel position: mostly inside the image, some zero, some any 12-bit pattern
   function automatic int pick_position();
      int roll;
      int mag;
      roll = $urandom_range(0, 99);
      mag  = $urandom_range(1, IMAGE_PIXELS);
      if (roll < 8)
         return 0;
      if (roll < 20)
         return $urandom_range(0, 4095) - 2048;
      return ($urandom_range(0, 1) != 0) ? -mag : mag;
   endfunction

   // Threshold: mostly near the usual sums, some full range, some extremes
   function automatic int pick_threshold();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return ($urandom_range(0, 1) != 0) ? THR_MAX : THR_MIN;
      if (roll < 30)
         return $urandom_range(0, 262143) - 131072;
      return $urandom_range(0, 32767) - 16384;
   endfunction

   // Hold the sender in bursts with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 32);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Offer one request and wait for its transfer
   task automatic send_request(input cmd_type cmd, input int pix, input int pval,
                               input int elem, input int slot, input int pos, input int thr);
      logic [REQ_DATA_W-1:0] packed_req;
      packed_req = '0;
      packed_req[PIX_IDX_LSB +: PIX_IDX_W]   = PIX_IDX_W'(pix);
      packed_req[PIX_VAL_LSB +: PIX_VAL_W]   = PIX_VAL_W'(pval);
      packed_req[ELEM_IDX_LSB +: ELEM_IDX_W] = ELEM_IDX_W'(elem);
      packed_req[SLOT_LSB +: SLOT_W]         = SLOT_W'(slot);
      packed_req[POS_LSB +: POS_W]           = POS_W'(pos);
      packed_req[THR_LSB +: THR_W]           = THR_W'(thr);
      req_tuser  <= cmd;
      req_tdata  <= packed_req;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pace_sender();
   endtask

   // Unused fields carry random content that the block must ignore
   task automatic load_pixel(input int pix, input int pval);
      send_request(CMD_LOAD_PIXEL, pix, pval, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic load_synapse(input int elem, input int slot, input int pos);
      send_request(CMD_LOAD_SYNAPSE, $urandom, $urandom, elem, slot, pos, $urandom);
   endtask

   task automatic load_threshold(input int elem, input int thr);
      send_request(CMD_LOAD_THRESHOLD, $urandom, $urandom, elem, $urandom, $urandom, thr);
   endtask

   task automatic evaluate();
      send_request(CMD_EVALUATE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Stop offering, wait for every owed firing word, then let the block settle
   task automatic drain_results(input int quiet_cycles);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
      repeat (quiet_cycles) @(posedge clock);
   endtask

   task automatic write_synapse_count(input int value);
      csr_valid <= 1'b1;
      csr_data  <= COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response back-pressure: ready runs, stall runs, random toggling, and long holds on request
   initial begin : rsp_pacing
      int span;
      int mode;
      forever begin
         if (holds_asked != holds_given) begin
            holds_given++;
            mode = 0;
            span = LONG_HOLD;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 48);
         end
         repeat (span) begin
            rsp_tready <= (mode == 1) ? ($urandom_range(0, 1) != 0) : (mode != 0);
            @(posedge clock);
         end
      end
   end

   // End the run if it hangs
   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("[address_decoder_firing_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned n;
      int unsigned roll;
      int unsigned e;
      int unsigned s;
      int unsigned p;
      bit          extra_eval;
      int          elem;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Fill every store entry an evaluation can read
      for (p = 0; p < IMAGE_PIXELS; p++)
         load_pixel(p, $urandom_range(0, 255));
      for (e = 0; e < ELEMENT_COUNT; e++) begin
         load_threshold(e, pick_threshold());
         for (s = 0; s < MAX_SYNAPSES; s++)
            load_synapse(e, s, pick_position());
      end

      // Field extremes, zero entries, positions past the image, ignored slots
      load_pixel(0, 0);
      load_pixel(IMAGE_PIXELS - 1, 255);
      load_synapse(0, 0, 0);
      load_synapse(0, 1, 1);
      load_synapse(0, 2, -1);
      load_synapse(0, 3, IMAGE_PIXELS);
      load_synapse(0, 4, -IMAGE_PIXELS);
      load_synapse(0, 5, IMAGE_PIXELS + 1);
      load_synapse(0, 11, 2047);
      load_synapse(ELEMENT_COUNT - 1, 11, -2048);
      load_synapse(ELEMENT_COUNT - 1, MAX_SYNAPSES, 5);
      load_synapse(ELEMENT_COUNT - 1, 15, 7);
      load_threshold(0, THR_MIN);
      load_threshold(ELEMENT_COUNT - 1, THR_MAX);
      load_threshold(1, 0);

      // Evaluate with the count left by reset
      evaluate();
      drain_results(IDLE_GUARD);

      // Zero count: every sum is zero
      write_synapse_count(0);
      evaluate();
      drain_results(IDLE_GUARD);

      // Count above the table: saturates
      write_synapse_count(15);
      evaluate();
      drain_results(IDLE_GUARD);

      // One synapse; hold the receiver off while loads queue up behind the evaluation
      write_synapse_count(1);
      holds_asked++;
      evaluate();
      for (n = 0; n < 4; n++)
         load_pixel($urandom_range(0, IMAGE_PIXELS - 1), $urandom_range(0, 255));
      drain_results(IDLE_GUARD);

      // Random phases: loads aimed mostly at the low elements, evaluations between them
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_synapse_count((phase == 0) ? MAX_SYNAPSES : $urandom_range(0, 15));
         extra_eval = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            elem = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 127)
                                              : $urandom_range(0, ELEMENT_COUNT - 1);
            if (roll < 4 && extra_eval) begin
               extra_eval = 1'b0;
               evaluate();
            end else if (roll < 35) begin
               load_pixel($urandom_range(0, IMAGE_PIXELS - 1), $urandom_range(0, 255));
            end else if (roll < 75) begin
               load_synapse(elem, ($urandom_range(0, 19) == 0) ? $urandom_range(12, 15)
                                                               : $urandom_range(0, 11),
                            pick_position());
            end else begin
               load_threshold(elem, pick_threshold());
            end
         end
         evaluate();
         drain_results(IDLE_GUARD);
      end

      drain_results(TAIL_CYCLES);
      if (fault_count == 0 && words_outstanding == 0)
         $display("[address_decoder_firing_core] OK");
      else
         $display("[address_decoder_firing_core] ERROR");
      $finish;
   end

endmodule

// ----- address_decoder_firing_core.f -----
+incdir+rtl/core
rtl/core/adfc_pkg.sv
rtl/core/adfc_ram.sv
rtl/core/adfc_ctrl.sv
rtl/core/adfc_datapath.sv
rtl/core/address_decoder_firing_core.sv
dv/address_decoder_firing_core_checker.sv
dv/address_decoder_firing_core_test.sv
